>>> rtl/ilt_pkg.sv
// Shared types and constants for the indexed list table.
// No dependencies; every other file in rtl/ imports this package.
package ilt_pkg;

  localparam int unsigned PosW    = 5;   // position, found_position, list_count ports
  localparam int unsigned ValW    = 32;  // item_value and read_value ports
  localparam int unsigned StatW   = 2;
  // Wide enough for any cell index, count or position up to the largest capacity
  localparam int unsigned CmpW    = 11;
  // Match bits examined per cycle during a find scan
  localparam int unsigned FindGrp = 8;

  typedef enum logic [1:0] {
    FnGet    = 2'd0,
    FnFind   = 2'd1,
    FnInsert = 2'd2,
    FnErase  = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StBadIndex = 2'd1,
    StFull     = 2'd2
  } status_e;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            ers;
    logic [PosW-1:0] pos;
  } ilt_ctl_t;

endpackage

>>> rtl/ilt_req_if.sv
// Request channel: valid/ready handshake carrying one list operation.
// Depends on ilt_pkg.
interface ilt_req_if import ilt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      func;
  logic [PosW-1:0] position;
  logic [ValW-1:0] item_value;

  modport source (output valid, output func, output position, output item_value,
                  input ready);
  modport sink   (input valid, input func, input position, input item_value,
                  output ready);
endinterface

>>> rtl/ilt_rsp_if.sv
// Response channel: valid/ready handshake carrying one operation result.
// Depends on ilt_pkg.
interface ilt_rsp_if import ilt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic [ValW-1:0]        read_value;
  logic signed [PosW-1:0] found_position;
  logic [PosW-1:0]        list_count;

  modport source (output valid, output status, output read_value,
                  output found_position, output list_count, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input list_count, output ready);
endinterface

>>> rtl/ilt_cell.sv
// One storage cell of the list: holds a word, shifts with its neighbors on
// insert/erase and compares its word against the search key. Depends on ilt_pkg.
module ilt_cell import ilt_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  ilt_ctl_t              ctl_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CmpW-1:0]       pos_w;

  assign pos_w = CmpW'(ctl_i.pos);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (MyIdx == pos_w) begin
        data_d = value_i;
      end else if (MyIdx > pos_w) begin
        data_d = left_i;
      end
    end else if (ctl_i.ers) begin
      if (MyIdx >= pos_w) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

>>> rtl/indexed_list_table.sv
// Indexed list table top level: cell chain plus request control and find scan.
// Depends on ilt_pkg, ilt_req_if, ilt_rsp_if and ilt_cell.
//
//   channel  dir  payload                                           handshake
//   req      in   func, position, item_value                        valid/ready
//   rsp      out  status, read_value, found_position, list_count    valid/ready
//
// Get, insert and erase complete on the accepting edge: the cells shift in
// parallel and the result lands in the output register.
// Find latches all cell compares, then scans the match bits FindGrp per cycle,
// waiting on the hit or final group while the output register is full.
// A request is taken only when no find is scanning and the output register is
// empty or being drained. Reset clears the count; cell contents are not reset.
module indexed_list_table import ilt_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilt_req_if.sink     req,
  ilt_rsp_if.source   rsp
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned HitW = ((CAPACITY + FindGrp - 1) / FindGrp) * FindGrp;
  localparam int unsigned EncW = $clog2(FindGrp);

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [HitW-1:0]        hit_q, hit_d;
  logic [CmpW-1:0]        base_q, base_d;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [ValW-1:0]        rd_q, rd_d;
  logic [PosW-1:0]        found_q, found_d;
  logic [PosW-1:0]        lcnt_q, lcnt_d;

  ilt_ctl_t               ctl;
  logic [DATA_WIDTH-1:0]  value;
  logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0]    match;

  logic                   out_free, acc;
  logic [CmpW-1:0]        pos_w, cnt_w;
  logic                   in_range, ins_pos_ok, is_full;
  logic [FindGrp-1:0]     grp;
  logic                   grp_any, scan_last;
  logic [EncW-1:0]        enc;
  logic [CmpW-1:0]        found_sum;

  assign value    = DATA_WIDTH'(req.item_value);
  assign out_free = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == StIdle) && out_free;
  assign acc      = req.valid && req.ready;

  assign pos_w      = CmpW'(req.position);
  assign cnt_w      = CmpW'(count_q);
  assign in_range   = pos_w < cnt_w;
  assign ins_pos_ok = pos_w <= cnt_w;
  assign is_full    = cnt_w >= CmpW'(CAPACITY);

  // Shift commands only for requests that actually change the list
  always_comb begin
    ctl.pos = req.position;
    ctl.ins = acc && (func_e'(req.func) == FnInsert) && ins_pos_ok && !is_full;
    ctl.ers = acc && (func_e'(req.func) == FnErase) && in_range;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = value;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    ilt_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .key_i   (value),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  // Lowest match group of the scan
  assign grp       = hit_q[FindGrp-1:0];
  assign grp_any   = |grp;
  assign scan_last = (base_q + CmpW'(FindGrp)) >= cnt_w;
  assign found_sum = base_q + CmpW'(enc);

  always_comb begin
    enc = '0;
    for (int i = FindGrp - 1; i >= 0; i--) begin
      if (grp[i]) begin
        enc = EncW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hit_d       = hit_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !rsp.ready;
    status_d    = status_q;
    rd_d        = rd_q;
    found_d     = found_q;
    lcnt_d      = lcnt_q;

    case (state_q)
      StIdle: begin
        if (acc) begin
          status_d = StOk;
          rd_d     = '0;
          found_d  = '1;
          case (func_e'(req.func))
            FnGet: begin
              if (in_range) begin
                rd_d = ValW'(cell_data[pos_w[IdxW-1:0]]);
              end else begin
                status_d = StBadIndex;
              end
              out_valid_d = 1'b1;
            end
            FnFind: begin
              for (int i = 0; i < HitW; i++) begin
                hit_d[i] = (i < CAPACITY) ? (match[i] && (CmpW'(i) < cnt_w)) : 1'b0;
              end
              base_d  = '0;
              state_d = StScan;
            end
            FnInsert: begin
              if (!ins_pos_ok) begin
                status_d = StBadIndex;
              end else if (is_full) begin
                status_d = StFull;
              end else begin
                count_d = count_q + CntW'(1);
              end
              out_valid_d = 1'b1;
            end
            FnErase: begin
              if (in_range) begin
                count_d = count_q - CntW'(1);
              end else begin
                status_d = StBadIndex;
              end
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
          lcnt_d = PosW'(count_d);
        end
      end
      StScan: begin
        if (grp_any || scan_last) begin
          if (out_free) begin
            status_d    = StOk;
            rd_d        = '0;
            found_d     = grp_any ? PosW'(found_sum) : '1;
            lcnt_d      = PosW'(count_q);
            out_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          hit_d  = hit_q >> FindGrp;
          base_d = base_q + CmpW'(FindGrp);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= '0;
      base_q      <= '0;
      status_q    <= StOk;
      rd_q        <= '0;
      found_q     <= '1;
      lcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      base_q      <= base_d;
      status_q    <= status_d;
      rd_q        <= rd_d;
      found_q     <= found_d;
      lcnt_q      <= lcnt_d;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.status         = status_q;
  assign rsp.read_value     = rd_q;
  assign rsp.found_position = $signed(found_q);
  assign rsp.list_count     = lcnt_q;

endmodule

>>> sim/ilt_list_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the indexed list table: keeps a shadow list, predicts each
// result and compares it with the response channel. Depends on ilt_pkg and
// the ilt_req_if / ilt_rsp_if interfaces.
module ilt_list_checker import ilt_pkg::*; #(
  parameter int unsigned Depth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilt_req_if          req,
  ilt_rsp_if          rsp,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    status_e                status;
    logic [ValW-1:0]        read_value;
    logic signed [PosW-1:0] found_position;
    logic [PosW-1:0]        list_count;
  } list_result_t;

  logic [ValW-1:0] words [Depth];
  int unsigned     used = 0;
  list_result_t    result_q [$];
  list_result_t    want;
  int unsigned     mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Apply one request to the shadow list and return what the block must report.
  function automatic list_result_t apply_request(input func_e fn,
                                                 input logic [PosW-1:0] pos,
                                                 input logic [ValW-1:0] val);
    list_result_t r;
    logic         hit;
    int unsigned  i;
    r.status         = StOk;
    r.read_value     = '0;
    r.found_position = '1;
    hit              = 1'b0;
    case (fn)
      FnGet: begin
        if (pos < used) r.read_value = words[pos];
        else r.status = StBadIndex;
      end
      FnFind: begin
        for (i = 0; i < used; i++) begin
          if (!hit && words[i] == val) begin
            hit              = 1'b1;
            r.found_position = PosW'(i);
          end
        end
      end
      FnInsert: begin
        if (pos > used) begin
          r.status = StBadIndex;
        end else if (used >= Depth) begin
          r.status = StFull;
        end else begin
          for (i = used; i > pos; i--) words[i] = words[i-1];
          words[pos] = val;
          used++;
        end
      end
      default: begin
        if (pos < used) begin
          for (i = pos; i + 1 < used; i++) words[i] = words[i+1];
          used--;
        end else begin
          r.status = StBadIndex;
        end
      end
    endcase
    r.list_count = PosW'(used);
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count_o++;
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used = 0;
      result_q.delete();
    end else begin
      // Response first: a result at this edge belongs to an older transaction.
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          note_failure($sformatf("unexpected result: status=%0d read=%h found=%0d count=%0d",
                                 rsp.status, rsp.read_value, rsp.found_position,
                                 rsp.list_count));
        end else begin
          want = result_q.pop_front();
          if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
              rsp.found_position !== want.found_position ||
              rsp.list_count !== want.list_count) begin
            note_failure($sformatf({"result mismatch: expected status=%0d read=%h ",
                                    "found=%0d count=%0d, got status=%0d read=%h ",
                                    "found=%0d count=%0d"},
                                   want.status, want.read_value, want.found_position,
                                   want.list_count, rsp.status, rsp.read_value,
                                   rsp.found_position, rsp.list_count));
          end
        end
      end
      if (req.valid && req.ready) begin
        result_q.push_back(apply_request(func_e'(req.func), req.position, req.item_value));
      end
    end
    pending_o = result_q.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the indexed list table regression: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on ilt_pkg, both channel
// interfaces, indexed_list_table and ilt_list_checker.
module testbench;
  import ilt_pkg::*;

  localparam int unsigned ListDepth   = 16;
  localparam int unsigned RandomItems = 925;
  localparam int unsigned IdleLimit   = 1000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ilt_req_if req_ch ();
  ilt_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned pending;

  indexed_list_table #(
    .CAPACITY  (ListDepth),
    .DATA_WIDTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  ilt_list_checker #(
    .Depth(ListDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Values that recur often so that finds hit and duplicates appear.
  logic [ValW-1:0] common_values [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                         32'h8000_0000, 32'h5555_5555, 32'hC3C3_3C3C};

  int unsigned fill = 0;           // occupancy as the stimulus sees it
  int unsigned op_tally [4] = '{0, 0, 0, 0};
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  int unsigned results_seen = 0;
  int unsigned full_hits = 0;
  int unsigned bad_index_hits = 0;
  int unsigned find_hits = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [ValW-1:0] pick_value();
    if ($urandom_range(0, 1) == 1) return common_values[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  task automatic push_request(input func_e fn, input logic [PosW-1:0] pos,
                              input logic [ValW-1:0] val);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= fn;
    req_ch.position   <= pos;
    req_ch.item_value <= val;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    @(negedge clk_i);
    op_tally[fn]++;
    case (fn)
      FnInsert: if (pos <= fill && fill < ListDepth) fill++;
      FnErase:  if (pos < fill) fill--;
      default: ;
    endcase
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Response side: random stall before each result, with stall-free stretches.
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
      @(negedge clk_i);
      if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (rsp_ch.status == StFull) full_hits++;
        if (rsp_ch.status == StBadIndex) bad_index_hits++;
        if (rsp_ch.found_position != '1) find_hits++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("no transaction for %0d cycles, %0d results outstanding",
                   IdleLimit, pending);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    func_e           fn;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    int unsigned     roll;
    int unsigned     top_pos;
    bit              grow;
    req_ch.valid      = 1'b0;
    req_ch.func       = FnGet;
    req_ch.position   = '0;
    req_ch.item_value = '0;
    grow              = 1'b1;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty list: every index is out of range, find misses.
    push_request(FnGet, 5'd0, '0);
    push_request(FnErase, 5'd0, '0);
    push_request(FnFind, 5'd0, 32'h0000_0000);
    push_request(FnInsert, 5'd1, 32'h1234_5678);
    // Insert into the empty list, at the end and at the front; extreme values.
    push_request(FnInsert, 5'd0, 32'h0000_0000);
    push_request(FnInsert, 5'd1, 32'hFFFF_FFFF);
    push_request(FnInsert, 5'd0, 32'hA5A5_A5A5);
    push_request(FnFind, 5'd31, 32'hFFFF_FFFF);
    push_request(FnGet, 5'd31, '0);
    // Fill to capacity with a duplicate of zero in the mix.
    while (fill < ListDepth) begin
      push_request(FnInsert, PosW'($urandom_range(0, fill)),
                   (fill == 8) ? 32'h0000_0000 : $urandom());
    end
    push_request(FnFind, 5'd0, 32'h0000_0000);
    push_request(FnInsert, 5'd16, 32'hFFFF_FFFF);
    push_request(FnInsert, 5'd17, 32'hFFFF_FFFF);
    push_request(FnGet, 5'd15, '0);
    push_request(FnErase, 5'd15, '0);
    push_request(FnErase, 5'd0, '0);
    push_request(FnErase, 5'd16, '0);
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      // Alternate filling and draining phases so both ends are reached often.
      if (n % 60 == 59) grow = !grow;
      if (n % 300 == 150) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        fn  = func_e'($urandom_range(0, 3));
        pos = PosW'($urandom_range(0, 31));
        val = $urandom();
      end else begin
        roll = $urandom_range(0, 99);
        if (grow) begin
          fn = (roll < 60) ? FnInsert : (roll < 75) ? FnGet : (roll < 90) ? FnFind : FnErase;
        end else begin
          fn = (roll < 20) ? FnInsert : (roll < 35) ? FnGet : (roll < 50) ? FnFind : FnErase;
        end
        top_pos = (fn == FnInsert) ? fill : ((fill == 0) ? 0 : fill - 1);
        pos     = PosW'($urandom_range(0, top_pos));
        if ($urandom_range(0, 19) == 0) pos = PosW'(fill + ((fn == FnInsert) ? 1 : 0));
        val = pick_value();
      end
      push_request(fn, pos, val);
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Requests: %0d get, %0d find, %0d insert, %0d erase; %0d results checked",
             op_tally[FnGet], op_tally[FnFind], op_tally[FnInsert], op_tally[FnErase],
             results_seen);
    $display("Full-list rejects %0d, bad-index rejects %0d, find hits %0d, mismatches %0d",
             full_hits, bad_index_hits, find_hits, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ilt_pkg.sv
rtl/ilt_req_if.sv
rtl/ilt_rsp_if.sv
rtl/ilt_cell.sv
rtl/indexed_list_table.sv
sim/ilt_list_checker.sv
sim/testbench.sv
